[src/channel_hint_history_update_core_assert.svh]
// assertion macros used by the checker of the channel hint history core
`ifndef CHANNEL_HINT_HISTORY_UPDATE_CORE_ASSERT_SVH
`define CHANNEL_HINT_HISTORY_UPDATE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CHHU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chhu check failed");

// consequent must hold in the cycle after the antecedent
`define CHHU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chhu check failed");

`endif

[src/chhu_pkg.sv]
// types and constants of the channel hint history core
package chhu_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int CAP_W      = 15;
    localparam int BOOST_W    = 15;
    localparam int BAND_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int SLOT_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_USAGE_CAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USAGE_BOOST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_24GHZ  = 2'd2;

    localparam logic [CAP_W-1:0]   USAGE_CAP_RESET   = 15'd10;
    localparam logic [BOOST_W-1:0] USAGE_BOOST_RESET = 15'd5;
    localparam logic [BAND_W-1:0]  BAND_24GHZ_RESET  = 8'd1;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_MARK   = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BAND_W-1:0] band;
        logic [CHAN_W-1:0] channel;
        logic              seen_outside_24ghz;
    } t_req_item;

    typedef struct packed {
        logic              matched;
        logic              stored_new;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        logic [BAND_W-1:0] evicted_band;
        logic [CHAN_W-1:0] evicted_channel;
    } t_rsp_item;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] count;
        logic               valid;
        logic               found;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINAL
    } t_state;

endpackage

[src/chhu_req_if.sv]
// request channel of the channel hint history core
interface chhu_req_if import chhu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/chhu_rsp_if.sv]
// result channel of the channel hint history core
interface chhu_rsp_if import chhu_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/chhu_entry_ram.sv]
// hint table storage: one write port, one registered read port, per-entry written bits
module chhu_entry_ram import chhu_pkg::*; #(
    parameter int ENTRIES = 8,
    parameter int AW      = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_data;
    logic [ENTRIES-1:0] r_init;
    logic               r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // an entry never written reads as the cleared reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_init[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_init[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_init ? r_rd_data : '0;

endmodule

[src/channel_hint_history_update_core.sv]
// channel hint history table: usage counts, ageing and replacement
//
// The table holds ENTRIES channel hints in a one-read, one-write RAM. Each
// request item is handled alone: the sequencer reads the entries one per
// cycle, modifies each as it returns and writes it straight back (a mark
// only on a hit), then writes any replacement entry and loads the result
// register in a final step. Each item passes through the walk, whose
// length is set by the single read port of the table, the final step and
// the idle state with ready high before the next item is accepted. The
// result sits in an output register, so the next item is taken while it
// waits; that item's final step then stalls until the waiting result is
// taken. The user must write configuration through i_cfg_we, i_cfg_idx
// and i_cfg_data only while the block is idle; the block does not enforce
// this. Writes to index 3 are dropped.
module channel_hint_history_update_core import chhu_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    chhu_req_if.sink              i_req,
    chhu_rsp_if.source            o_rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int IW = $clog2(ENTRIES + 1);

    t_state n_state;
    t_state r_state;

    logic [IW-1:0]      r_idx;
    logic               r_dv;
    logic [AW-1:0]      r_pidx;
    t_req_item          r_req;
    logic               r_matched;
    logic [AW-1:0]      r_slot;
    logic               r_have_cand;
    logic [COUNT_W-1:0] r_least;
    logic [AW-1:0]      r_cand;
    logic               r_cand_valid;
    logic [BAND_W-1:0]  r_cand_band;
    logic [CHAN_W-1:0]  r_cand_chan;
    logic [CAP_W-1:0]   r_cap;
    logic [BOOST_W-1:0] r_boost;
    logic [BAND_W-1:0]  r_b24;
    logic               r_ov;
    t_rsp_item          r_out;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          in_acc;
    logic          proc;
    logic          final_go;
    logic          last_entry;
    logic          save;
    logic          hit;
    logic          take_cand;
    logic          store;
    t_entry        upd;

    chhu_entry_ram #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign in_acc     = i_req.valid && i_req.ready;
    assign last_entry = r_dv && (r_pidx == AW'(ENTRIES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (last_entry) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (final_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        rd_en       = 1'b0;
        proc        = 1'b0;
        final_go    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_WALK: begin
                rd_en = (r_idx < IW'(ENTRIES));
                proc  = r_dv;
            end
            S_FINAL: begin
                final_go = !r_ov || o_rsp.ready;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign rd_addr = r_idx[AW-1:0];

    // a blocked 2.4 GHz record still ages but never boosts or stores
    assign save  = !(r_req.seen_outside_24ghz && (r_req.band == r_b24));
    assign hit   = !r_matched && rd_data.valid && (rd_data.band == r_req.band)
                   && (rd_data.channel == r_req.channel);
    assign take_cand = (r_req.req_type == REQ_RECORD) && !hit
                       && (!r_have_cand || (rd_data.count < r_least));
    assign store = (r_req.req_type == REQ_RECORD) && save && !r_matched;

    always_comb begin
        upd = rd_data;
        if (r_req.req_type == REQ_MARK) begin
            if (hit) begin
                upd.found = 1'b1;
            end
        end else begin
            upd.found = 1'b0;
            if (hit) begin
                if (save && (rd_data.count < COUNT_W'(r_cap))) begin
                    upd.count = rd_data.count + COUNT_W'(r_boost);
                end
            end else if (take_cand && (rd_data.count != '0) && !rd_data.found) begin
                upd.count = rd_data.count - COUNT_W'(1);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = upd;
        if (final_go) begin
            wr_en           = store;
            wr_addr         = r_cand;
            wr_data.band    = r_req.band;
            wr_data.channel = r_req.channel;
            wr_data.count   = COUNT_W'(r_boost);
            wr_data.valid   = 1'b1;
            wr_data.found   = 1'b0;
        end else if (proc) begin
            wr_en = (r_req.req_type == REQ_RECORD) || hit;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_matched   <= 1'b0;
            r_have_cand <= 1'b0;
            r_ov        <= 1'b0;
            r_cap       <= USAGE_CAP_RESET;
            r_boost     <= USAGE_BOOST_RESET;
            r_b24       <= BAND_24GHZ_RESET;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_idx       <= '0;
                r_dv        <= 1'b0;
                r_matched   <= 1'b0;
                r_have_cand <= 1'b0;
            end else begin
                if (r_state == S_WALK) begin
                    r_dv <= rd_en;
                end
                if (rd_en) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (proc && hit) begin
                    r_matched <= 1'b1;
                end
                if (proc && take_cand) begin
                    r_have_cand <= 1'b1;
                end
            end
            if (final_go) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_USAGE_CAP) begin
                    r_cap <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_USAGE_BOOST) begin
                    r_boost <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_BAND_24GHZ) begin
                    r_b24 <= i_cfg_data[BAND_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_req.data;
            r_slot <= '0;
        end
        if (rd_en) begin
            r_pidx <= r_idx[AW-1:0];
        end
        if (proc && hit) begin
            r_slot <= r_pidx;
        end
        if (proc && take_cand) begin
            r_least      <= upd.count;
            r_cand       <= r_pidx;
            r_cand_valid <= rd_data.valid;
            r_cand_band  <= rd_data.band;
            r_cand_chan  <= rd_data.channel;
        end
        if (final_go) begin
            r_out.matched         <= r_matched;
            r_out.stored_new      <= store;
            r_out.slot            <= store ? SLOT_W'(r_cand) : SLOT_W'(r_slot);
            r_out.evicted_valid   <= store && r_cand_valid;
            r_out.evicted_band    <= store ? r_cand_band : '0;
            r_out.evicted_channel <= store ? r_cand_chan : '0;
        end
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

endmodule

[src/chhu_checker.sv]
// port-level checks of the channel hint history core, bound to the top level
`include "channel_hint_history_update_core_assert.svh"

module chhu_checker import chhu_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_req_valid,
    input logic      i_req_ready,
    input logic      i_rsp_valid,
    input logic      i_rsp_ready,
    input t_rsp_item i_rsp_data
);

    // one item at a time: the table walk starts at once
    `CHHU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    `CHHU_ASSERT_SAME(a_hit_or_store, i_clk, i_rst_n, i_rsp_valid, !(i_rsp_data.matched && i_rsp_data.stored_new))

    `CHHU_ASSERT_SAME(a_evict_needs_store, i_clk, i_rst_n, i_rsp_valid && !i_rsp_data.stored_new, !i_rsp_data.evicted_valid && (i_rsp_data.evicted_band == '0) && (i_rsp_data.evicted_channel == '0))

    `CHHU_ASSERT_SAME(a_slot_zero_on_miss, i_clk, i_rst_n, i_rsp_valid && !i_rsp_data.matched && !i_rsp_data.stored_new, i_rsp_data.slot == '0)

    `CHHU_ASSERT_NEXT(a_rsp_held, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))

endmodule

bind channel_hint_history_update_core chhu_checker u_chhu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

[dv/channel_hint_history_update_core_tb.sv]
// self-checking testbench of the channel hint history core
`timescale 1ns / 100ps
module channel_hint_history_update_core_tb;
    import chhu_pkg::*;

    localparam int ENTRIES          = 8;
    localparam int HOT_PAIRS        = 12;
    localparam int DRAIN_CYCLES     = ENTRIES + 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_IDLE         = 19;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    chhu_req_if req_ch ();
    chhu_rsp_if rsp_ch ();

    channel_hint_history_update_core #(.ENTRIES(ENTRIES)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the hint table and its registers
    logic [BAND_W-1:0]  hint_band  [ENTRIES];
    logic [CHAN_W-1:0]  hint_chan  [ENTRIES];
    logic [COUNT_W-1:0] hint_count [ENTRIES];
    logic               hint_valid [ENTRIES];
    logic               hint_found [ENTRIES];
    logic [CAP_W-1:0]   cfg_cap    = USAGE_CAP_RESET;
    logic [BOOST_W-1:0] cfg_boost  = USAGE_BOOST_RESET;
    logic [BAND_W-1:0]  cfg_band24 = BAND_24GHZ_RESET;

    t_req_item req_pending [$];
    t_rsp_item rsp_expected [$];

    logic [BAND_W-1:0] hot_band [HOT_PAIRS];
    logic [CHAN_W-1:0] hot_chan [HOT_PAIRS];

    int          mismatch_count = 0;
    int unsigned req_gap        = 0;
    int unsigned rsp_wait       = 0;
    int          long_hold_reqs = 0;
    int          long_hold_done = 0;
    logic        req_gaps_on    = 1'b0;
    logic        rsp_stalls_on  = 1'b0;

    // applies one request to the shadow table and returns the result it gives
    function automatic t_rsp_item hint_table_update(t_req_item rq);
        t_rsp_item          res;
        logic               store_ok;
        logic               have_cand;
        logic               hit;
        logic [COUNT_W-1:0] least;
        int                 cand;
        res       = '0;
        have_cand = 1'b0;
        least     = '0;
        cand      = 0;
        store_ok  = !(rq.seen_outside_24ghz && rq.band == cfg_band24);
        for (int i = 0; i < ENTRIES; i++) begin
            hit = !res.matched && hint_valid[i] && hint_band[i] == rq.band
                  && hint_chan[i] == rq.channel;
            if (rq.req_type == REQ_MARK) begin
                if (hit) begin
                    hint_found[i] = 1'b1;
                    res.matched   = 1'b1;
                    res.slot      = SLOT_W'(i);
                end
            end else begin
                if (hit) begin
                    if (store_ok && hint_count[i] < cfg_cap)
                        hint_count[i] = hint_count[i] + COUNT_W'(cfg_boost);
                    res.matched = 1'b1;
                    res.slot    = SLOT_W'(i);
                end else if (!have_cand || hint_count[i] < least) begin
                    // ageing only touches entries that set a new minimum
                    if (hint_count[i] != 0 && !hint_found[i])
                        hint_count[i] = hint_count[i] - 1'b1;
                    least     = hint_count[i];
                    cand      = i;
                    have_cand = 1'b1;
                end
                hint_found[i] = 1'b0;
            end
        end
        if (rq.req_type == REQ_RECORD && store_ok && !res.matched) begin
            res.stored_new      = 1'b1;
            res.slot            = SLOT_W'(cand);
            res.evicted_valid   = hint_valid[cand];
            res.evicted_band    = hint_band[cand];
            res.evicted_channel = hint_chan[cand];
            hint_band[cand]     = rq.band;
            hint_chan[cand]     = rq.channel;
            hint_count[cand]    = COUNT_W'(cfg_boost);
            hint_valid[cand]    = 1'b1;
            hint_found[cand]    = 1'b0;
        end
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void push_req(logic kind, logic [BAND_W-1:0] band,
                                     logic [CHAN_W-1:0] chan, logic outside);
        t_req_item rq;
        rq.req_type           = kind;
        rq.band               = band;
        rq.channel            = chan;
        rq.seen_outside_24ghz = outside;
        req_pending.push_back(rq);
    endfunction

    // a few pairs recur so that hits, marks and evictions are common
    function automatic void pick_hot_pairs();
        for (int k = 0; k < HOT_PAIRS; k++) begin
            hot_band[k] = ($urandom_range(0, 2) == 0) ? cfg_band24
                                                      : BAND_W'($urandom_range(0, 255));
            hot_chan[k] = CHAN_W'($urandom_range(0, 255));
        end
    endfunction

    function automatic t_req_item gen_hint_req();
        t_req_item rq;
        int        k;
        k                     = $urandom_range(0, HOT_PAIRS - 1);
        rq.req_type           = ($urandom_range(0, 9) < 3) ? REQ_MARK : REQ_RECORD;
        rq.seen_outside_24ghz = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
            rq.band    = hot_band[k];
            rq.channel = hot_chan[k];
        end else begin
            rq.band    = BAND_W'($urandom_range(0, 255));
            rq.channel = CHAN_W'($urandom_range(0, 255));
        end
        return rq;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_USAGE_CAP:   cfg_cap = val;
            CFG_USAGE_BOOST: cfg_boost = val;
            CFG_BAND_24GHZ:  cfg_band24 = val[BAND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (req_pending.size() != 0 || req_ch.valid || rsp_expected.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(int n);
        @(negedge i_clk);
        repeat (n) req_pending.push_back(gen_hint_req());
        wait_idle();
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_gap      <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                rsp_expected.push_back(hint_table_update(req_ch.data));
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap != 0) begin
                    req_gap      <= req_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (req_pending.size() != 0) begin
                    req_ch.data  <= req_pending.pop_front();
                    req_ch.valid <= 1'b1;
                    req_gap      <= req_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (rsp_expected.size() == 0) begin
                    $error("result item with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = rsp_expected.pop_front();
                    check_field("matched", want.matched, rsp_ch.data.matched);
                    check_field("stored_new", want.stored_new, rsp_ch.data.stored_new);
                    check_field("slot", want.slot, rsp_ch.data.slot);
                    check_field("evicted_valid", want.evicted_valid,
                                rsp_ch.data.evicted_valid);
                    check_field("evicted_band", want.evicted_band,
                                rsp_ch.data.evicted_band);
                    check_field("evicted_channel", want.evicted_channel,
                                rsp_ch.data.evicted_channel);
                end
                rsp_wait = rsp_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (rsp_wait != 0) begin
                rsp_wait--;
            end
            if (long_hold_done != long_hold_reqs) begin
                rsp_wait       = LONG_HOLD_CYCLES;
                long_hold_done = long_hold_reqs;
            end
            rsp_ch.ready <= (rsp_wait == 0);
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            hint_band[i]  = '0;
            hint_chan[i]  = '0;
            hint_count[i] = '0;
            hint_valid[i] = 1'b0;
            hint_found[i] = 1'b0;
        end
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values written back, and a write to the unused index is dropped
        write_reg(CFG_USAGE_CAP, USAGE_CAP_RESET);
        write_reg(CFG_USAGE_BOOST, USAGE_BOOST_RESET);
        write_reg(CFG_BAND_24GHZ, CFG_DATA_W'(BAND_24GHZ_RESET));
        write_reg(CFG_IDX_UNUSED, '1);

        @(negedge i_clk);
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        push_req(REQ_MARK, 8'd0, 8'd0, 1'b0);       // mark on an empty table
        push_req(REQ_RECORD, 8'd0, 8'd0, 1'b0);
        push_req(REQ_RECORD, 8'd0, 8'd0, 1'b0);     // hit below the cap
        push_req(REQ_RECORD, 8'd0, 8'd0, 1'b0);     // hit at the cap
        push_req(REQ_RECORD, 8'd255, 8'd255, 1'b1);
        push_req(REQ_RECORD, 8'd1, 8'd6, 1'b1);     // blocked 2.4 GHz miss
        push_req(REQ_RECORD, 8'd1, 8'd6, 1'b0);
        push_req(REQ_MARK, 8'd1, 8'd6, 1'b1);
        push_req(REQ_RECORD, 8'd2, 8'd36, 1'b0);    // ageing skips the marked entry
        push_req(REQ_MARK, 8'd1, 8'd6, 1'b0);
        push_req(REQ_RECORD, 8'd1, 8'd6, 1'b1);     // blocked hit, no boost
        push_req(REQ_MARK, 8'd255, 8'd255, 1'b0);
        push_req(REQ_MARK, 8'd7, 8'd7, 1'b0);       // mark miss on a busy table
        for (int k = 0; k < 9; k++)
            push_req(REQ_RECORD, 8'd3, CHAN_W'(100 + k), 1'b0);
        push_req(REQ_RECORD, 8'd255, 8'd0, 1'b0);
        push_req(REQ_RECORD, 8'd0, 8'd255, 1'b1);
        wait_idle();

        pick_hot_pairs();
        run_random(200);

        // cap and boost set to 1; the receiver holds off once, early in the run
        write_reg(CFG_USAGE_CAP, 15'd1);
        write_reg(CFG_USAGE_BOOST, 15'd1);
        write_reg(CFG_BAND_24GHZ, 15'd0);
        pick_hot_pairs();
        @(negedge i_clk);
        long_hold_reqs = long_hold_reqs + 1;
        run_random(150);

        // largest cap and boost, no idling on either side
        write_reg(CFG_USAGE_CAP, 15'd32767);
        write_reg(CFG_USAGE_BOOST, 15'd32767);
        write_reg(CFG_BAND_24GHZ, 15'd255);
        pick_hot_pairs();
        @(negedge i_clk);
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        run_random(150);

        write_reg(CFG_USAGE_CAP, CFG_DATA_W'($urandom_range(1, 40)));
        write_reg(CFG_USAGE_BOOST, CFG_DATA_W'($urandom_range(1, 12)));
        write_reg(CFG_BAND_24GHZ, CFG_DATA_W'($urandom_range(0, 255)));
        pick_hot_pairs();
        @(negedge i_clk);
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        run_random(100);
        // sender has paused until the table drained
        run_random(100);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
